/* rtl/motor_speed_observer_assert.svh */
// ----------------------------------------------------------------------------
// Motor speed observer assertion macros
// Shared concurrent assertion forms, clocked on clk with synchronous reset.
// ----------------------------------------------------------------------------
`ifndef MOTOR_SPEED_OBSERVER_ASSERT_SVH
`define MOTOR_SPEED_OBSERVER_ASSERT_SVH

// same-cycle implication
`define MSO_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("motor_speed_observer: assertion failed");

// next-cycle implication
`define MSO_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("motor_speed_observer: assertion failed");

`endif

/* rtl/mso_pkg.sv */
// ----------------------------------------------------------------------------
// Motor speed observer package
// Word and coefficient types, register indexes and fixed-point helpers.
// ----------------------------------------------------------------------------
package mso_pkg;

  localparam int WORD_W  = 32;
  localparam int FRAC_W  = 30;
  localparam int PROD_W  = 2 * WORD_W - FRAC_W;
  localparam int ACC_W   = PROD_W + 2;
  localparam int IDX_W   = 3;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic        [IDX_W-1:0]  idx_t;

  localparam idx_t REG_VEL_SELF = 3'd0;
  localparam idx_t REG_VEL_IN   = 3'd1;
  localparam idx_t REG_POS_VEL  = 3'd2;
  localparam idx_t REG_POS_IN   = 3'd3;
  localparam idx_t REG_VEL_CORR = 3'd4;
  localparam idx_t REG_POS_CORR = 3'd5;

  typedef struct packed {
    word_t vel_self;
    word_t vel_in;
    word_t pos_vel;
    word_t pos_in;
    word_t vel_corr;
    word_t pos_corr;
  } coef_t;

  // Q16.16 times Q2.30, floored to Q18.16 at full width
  function automatic prod_t qmul(input word_t sig, input word_t coef);
    logic signed [2*WORD_W-1:0] p;
    p = (2*WORD_W)'(sig) * (2*WORD_W)'(coef);
    return p[2*WORD_W-1:FRAC_W];
  endfunction

  function automatic word_t sat_word(input acc_t x);
    word_t r;
    if (x > acc_t'(word_t'({1'b0, {(WORD_W-1){1'b1}}}))) begin
      r = {1'b0, {(WORD_W-1){1'b1}}};
    end else if (x < acc_t'(word_t'({1'b1, {(WORD_W-1){1'b0}}}))) begin
      r = {1'b1, {(WORD_W-1){1'b0}}};
    end else begin
      r = x[WORD_W-1:0];
    end
    return r;
  endfunction

endpackage

/* rtl/mso_if.sv */
// ----------------------------------------------------------------------------
// Motor speed observer channel interfaces
// Sample, estimate and configuration channels with valid/ready transfer.
// ----------------------------------------------------------------------------
interface mso_in_if;
  logic          valid;
  logic          ready;
  mso_pkg::word_t measured_position;
  mso_pkg::word_t applied_voltage;

  modport source (output valid, measured_position, applied_voltage, input ready);
  modport sink   (input valid, measured_position, applied_voltage, output ready);
endinterface

interface mso_out_if;
  logic          valid;
  logic          ready;
  mso_pkg::word_t velocity_estimate;
  mso_pkg::word_t position_estimate;

  modport source (output valid, velocity_estimate, position_estimate, input ready);
  modport sink   (input valid, velocity_estimate, position_estimate, output ready);
endinterface

interface mso_cfg_if;
  logic          valid;
  logic          ready;
  mso_pkg::idx_t  index;
  mso_pkg::word_t data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/motor_speed_observer.sv */
// ----------------------------------------------------------------------------
// Motor speed observer
// Discrete observer tracking motor velocity and position from samples.
// ----------------------------------------------------------------------------
// Samples pass an input register stage, then the output estimate registers.
// Throughput: 1 sample per cycle unless stalled, set by the estimate feedback.
// The estimate registers double as the output payload.
// Reset clears coefficients, both estimates and all valid flags.
// ----------------------------------------------------------------------------
module motor_speed_observer (
  input  logic       clk,
  input  logic       rst_n,
  mso_in_if.sink     in_ch,
  mso_out_if.source  out_ch,
  mso_cfg_if.sink    cfg_ch
);
  import mso_pkg::*;

  `include "motor_speed_observer_assert.svh"

  coef_t coef_r;
  logic  in_valid_r;
  word_t theta_r;
  word_t volt_r;
  logic  out_valid_r;
  word_t vel_est_r;
  word_t pos_est_r;
  word_t vel_nxt;
  word_t pos_nxt;
  logic  fire;

  assign fire         = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !in_valid_r || fire;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid             = out_valid_r;
  assign out_ch.velocity_estimate = vel_est_r;
  assign out_ch.position_estimate = pos_est_r;

  mso_update u_update (
    .coef    (coef_r),
    .theta   (theta_r),
    .volt    (volt_r),
    .vel     (vel_est_r),
    .pos     (pos_est_r),
    .vel_new (vel_nxt),
    .pos_new (pos_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_VEL_SELF: coef_r.vel_self <= cfg_ch.data;
        REG_VEL_IN:   coef_r.vel_in   <= cfg_ch.data;
        REG_POS_VEL:  coef_r.pos_vel  <= cfg_ch.data;
        REG_POS_IN:   coef_r.pos_in   <= cfg_ch.data;
        REG_VEL_CORR: coef_r.vel_corr <= cfg_ch.data;
        REG_POS_CORR: coef_r.pos_corr <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      theta_r <= in_ch.measured_position;
      volt_r  <= in_ch.applied_voltage;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      vel_est_r   <= '0;
      pos_est_r   <= '0;
    end else begin
      if (fire) begin
        out_valid_r <= 1'b1;
        vel_est_r   <= vel_nxt;
        pos_est_r   <= pos_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  `MSO_ASSERT_NXT(a_fire_gives_result, fire, out_valid_r)
  `MSO_ASSERT_NXT(a_stalled_sample_held, in_valid_r && !fire, in_valid_r)
  `MSO_ASSERT_NXT(a_transfer_loads_stage, in_ch.valid && in_ch.ready, in_valid_r)
  `MSO_ASSERT_NXT(a_state_moves_on_item, !in_valid_r, $stable(vel_est_r) && $stable(pos_est_r))

endmodule

/* rtl/mso_update.sv */
// ----------------------------------------------------------------------------
// Motor speed observer update
// One observer step: saturated position error, six products, saturated sums.
// ----------------------------------------------------------------------------
module mso_update (
  input  mso_pkg::coef_t coef,
  input  mso_pkg::word_t theta,
  input  mso_pkg::word_t volt,
  input  mso_pkg::word_t vel,
  input  mso_pkg::word_t pos,
  output mso_pkg::word_t vel_new,
  output mso_pkg::word_t pos_new
);
  import mso_pkg::*;

  acc_t  err_wide;
  word_t err;
  acc_t  vel_sum;
  acc_t  pos_sum;

  assign err_wide = acc_t'(theta) - acc_t'(pos);
  assign err      = sat_word(err_wide);

  assign vel_sum = acc_t'(qmul(vel, coef.vel_self))
                 + acc_t'(qmul(volt, coef.vel_in))
                 + acc_t'(qmul(err, coef.vel_corr));

  assign pos_sum = acc_t'(qmul(vel, coef.pos_vel))
                 + acc_t'(pos)
                 + acc_t'(qmul(volt, coef.pos_in))
                 + acc_t'(qmul(err, coef.pos_corr));

  assign vel_new = sat_word(vel_sum);
  assign pos_new = sat_word(pos_sum);

endmodule
